@@ rtl/lrbm_pkg.sv @@
package lrbm_pkg;

    localparam int REG_W    = 3;
    localparam int NUM_REGS = 8;
    localparam int IDX_W    = 3;

    localparam logic [15:0] RANGE_LO     = 16'h4100;
    localparam logic [15:0] RANGE_HI     = 16'h5FFF;
    localparam logic [15:0] DECODE_MASK  = 16'h0101;
    localparam logic [15:0] DECODE_INDEX = 16'h0100;
    localparam logic [15:0] DECODE_DATA  = 16'h0101;
    localparam logic [7:0]  DIP_FORCE    = 8'h04;

    typedef enum logic [1:0] {
        KIND_READ       = 2'd0,
        KIND_WRITE      = 2'd1,
        KIND_SOFT_RESET = 2'd2,
        KIND_POWER_ON   = 2'd3
    } kind_t;

    // Registers that feed the bank decode, as they stand after the current item
    typedef struct packed {
        logic [REG_W-1:0] r2;
        logic [REG_W-1:0] r4;
        logic [REG_W-1:0] r5;
        logic [REG_W-1:0] r6;
        logic [REG_W-1:0] r7;
    } bank_view_t;

endpackage

@@ rtl/latched_register_bank_mapper_core.sv @@
// An item passes the input register, then the result register, to the master side.
// Throughput: one item per cycle; the input register advances whenever the result
// register is empty or being drained, so the only limit is the downstream tready.
// Reset (rst_n low, asynchronous): both pipeline registers empty, register file,
// index and dip flag cleared, variant back to the first board formula.
module latched_register_bank_mapper_core
    import lrbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic        cfg_wdata,      // variant

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] address, [23:16] write_data, [31:24] open_bus
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [7:0] read_data, [10:8] prg_bank,
                                        // [16:11] chr_bank, [18:17] mirroring, [23:19] zero
);

    // Configuration: one bit; write it only while the block is idle (not enforced here)
    logic variant_reg;

    // Input register stage
    logic        in_valid_reg;
    kind_t       in_kind_reg;
    logic [15:0] in_addr_reg;
    logic [7:0]  in_wdata_reg;
    logic [7:0]  in_bus_reg;

    // Result register stage
    logic        out_valid_reg;
    logic [18:0] out_data_reg;

    logic        advance;
    logic        out_free;

    logic [7:0]  read_data;
    bank_view_t  view;
    logic [2:0]  prg_bank;
    logic [5:0]  chr_bank;
    logic [1:0]  mirroring;

    // The result register frees up when empty or when its item is taken this cycle
    assign out_free      = !out_valid_reg || m_axis_tready;
    // Move the held item through the register file into the result register
    assign advance       = in_valid_reg && out_free;
    // Take a new item when the input register is empty or moving on
    assign s_axis_tready = !in_valid_reg || out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            variant_reg <= 1'b0;
        else if (cfg_we)
            variant_reg <= cfg_wdata;
    end

    // Input register: hold the item until the result side can take it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_kind_reg  <= kind_t'(s_axis_tuser);
            in_addr_reg  <= s_axis_tdata[15:0];
            in_wdata_reg <= s_axis_tdata[23:16];
            in_bus_reg   <= s_axis_tdata[31:24];
        end
    end

    // Register file updates its state on the same edge that loads the result,
    // so the following item already sees the new contents.
    lrbm_regfile u_regfile (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .kind       (in_kind_reg),
        .address    (in_addr_reg),
        .write_data (in_wdata_reg),
        .open_bus   (in_bus_reg),
        .read_data  (read_data),
        .view       (view)
    );

    // Banks are decoded from the register contents after this item's update
    lrbm_bank_decode u_bank_decode (
        .variant   (variant_reg),
        .view      (view),
        .prg_bank  (prg_bank),
        .chr_bank  (chr_bank),
        .mirroring (mirroring)
    );

    // Result register: load on advance, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= advance;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= {mirroring, chr_bank, prg_bank, read_data};
    end

endmodule

@@ rtl/lrbm_regfile.sv @@
module lrbm_regfile
    import lrbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  kind_t      kind,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  logic [7:0]  open_bus,
    output logic [7:0]  read_data,
    output bank_view_t  view
);

    logic [REG_W-1:0] bank_reg  [NUM_REGS];
    logic [REG_W-1:0] bank_next [NUM_REGS];
    logic [IDX_W-1:0] index_reg;
    logic [IDX_W-1:0] index_next;
    logic             dip_reg;
    logic             dip_next;

    logic             in_range;
    logic [15:0]      sel;
    logic [7:0]       data_eff;
    logic [REG_W-1:0] cur_val;

    assign in_range = (address >= RANGE_LO) && (address <= RANGE_HI);
    assign sel      = address & DECODE_MASK;
    assign data_eff = dip_reg ? (write_data | DIP_FORCE) : write_data;
    assign cur_val  = bank_reg[index_reg];

    always_comb
    begin
        bank_next  = bank_reg;
        index_next = index_reg;
        dip_next   = dip_reg;
        read_data  = open_bus;
        case (kind)
            KIND_READ:
            begin
                if (in_range && sel == DECODE_DATA)
                begin
                    if (dip_reg)
                        read_data = {open_bus[7:2], cur_val[1:0]};
                    else
                        read_data = {open_bus[7:3], cur_val};
                end
            end
            KIND_WRITE:
            begin
                if (in_range)
                begin
                    if (sel == DECODE_INDEX)
                        index_next = data_eff[IDX_W-1:0];
                    else if (sel == DECODE_DATA)
                        bank_next[index_reg] = data_eff[REG_W-1:0];
                end
            end
            KIND_SOFT_RESET:
            begin
                dip_next  = ~dip_reg;
                bank_next = '{default: '0};
            end
            KIND_POWER_ON:
            begin
                dip_next  = 1'b0;
                bank_next = '{default: '0};
            end
            default:
            begin
                read_data = open_bus;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg  <= '{default: '0};
            index_reg <= '0;
            dip_reg   <= 1'b0;
        end
        else if (step)
        begin
            bank_reg  <= bank_next;
            index_reg <= index_next;
            dip_reg   <= dip_next;
        end
    end

    assign view.r2 = bank_next[2];
    assign view.r4 = bank_next[4];
    assign view.r5 = bank_next[5];
    assign view.r6 = bank_next[6];
    assign view.r7 = bank_next[7];

endmodule

@@ rtl/lrbm_bank_decode.sv @@
module lrbm_bank_decode
    import lrbm_pkg::*;
(
    input  logic       variant,
    input  bank_view_t view,
    output logic [2:0] prg_bank,
    output logic [5:0] chr_bank,
    output logic [1:0] mirroring
);

    assign prg_bank  = {view.r5[2:1], view.r5[0] | view.r2[0]};
    assign chr_bank  = variant ? {1'b0, view.r6, view.r4[0], view.r2[0]}
                               : {view.r2, view.r4[0], view.r6[1:0]};
    assign mirroring = view.r7[2:1];

endmodule
